// File: sv/mi3_pkg.sv
// Shared widths, types and the cofactor index table for the 3x3 matrix inverse.
package mi3_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ELEM_W = 32;
    localparam int N_ELEM = 9;
    localparam int TOL_W  = 31;

    // Internal exact widths.
    localparam int PROD_W = 2 * ELEM_W;       // element times element
    localparam int ADJ_W  = PROD_W + 1;       // difference of two products
    localparam int MAG_W  = PROD_W;           // cofactor magnitude
    localparam int TERM_W = MAG_W + ELEM_W;   // one expansion term magnitude
    localparam int DET_W  = TERM_W + 2;       // signed determinant
    localparam int DMAG_W = TERM_W + 1;       // determinant magnitude

    // Quotient bits produced by the divider, including the overflow bit.
    localparam int QUO_W   = ELEM_W + 2;
    // Divider latency: entry, one stage per quotient bit, round, clamp, sign.
    localparam int DIV_LAT = QUO_W + 4;

    typedef logic signed [ELEM_W-1:0] t_elem;

    // One finished quotient from a divider lane.
    typedef struct packed {
        logic              sat;
        logic [ELEM_W-1:0] val;
    } t_div_res;

    // Adjugate element c equals m[a]*m[b] - m[c]*m[d], listed as {a, b, c, d}.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

// File: sv/mi3_div.sv
// Pipelined restoring divider lane: rounded, clamped signed quotient of one adjugate element.
module mi3_div #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [mi3_pkg::MAG_W-1:0]   i_num_mag,
    input  logic [mi3_pkg::DMAG_W-1:0]  i_den,
    input  logic                        i_neg,
    output mi3_pkg::t_div_res           o_res
);
    import mi3_pkg::*;

    localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
    localparam int CMP_W = DMAG_W + QUO_W;

    logic [NUM_W-1:0]  r_rem [QUO_W+1];
    logic [QUO_W-1:0]  r_quo [QUO_W+1];
    logic [DMAG_W-1:0] r_den [QUO_W+1];
    logic              r_neg [QUO_W+1];

    logic [QUO_W-1:0]  r_q_a;
    logic              r_rnd_a;
    logic              r_neg_a;
    logic [ELEM_W-1:0] r_mag_b;
    logic              r_sat_b;
    logic              r_neg_b;
    t_div_res          r_res;

    logic              w_rnd;
    logic [QUO_W-1:0]  w_qr;
    logic [ELEM_W:0]   w_lim;
    logic              w_sat;

    // Entry register: the numerator is the cofactor magnitude scaled up.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {i_num_mag, {(2 * FRAC_BITS){1'b0}}};
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int SH = QUO_W - 1 - j;
        logic [CMP_W-1:0] w_dsh;
        logic             w_ge;

        assign w_dsh = CMP_W'(r_den[j]) << SH;
        assign w_ge  = CMP_W'(r_rem[j]) >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_dsh[NUM_W-1:0]) : r_rem[j];
                r_quo[j+1] <= {r_quo[j][QUO_W-2:0], w_ge};
                r_den[j+1] <= r_den[j];
                r_neg[j+1] <= r_neg[j];
            end
        end
    end

    // Round half away from zero: add one to the magnitude when twice the remainder reaches the divisor.
    assign w_rnd = CMP_W'({r_rem[QUO_W], 1'b0}) >= CMP_W'(r_den[QUO_W]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_a   <= r_quo[QUO_W];
            r_rnd_a <= w_rnd;
            r_neg_a <= r_neg[QUO_W];
        end
    end

    // Clamp to the signed range; the top quotient bit already means overflow.
    assign w_qr  = {1'b0, r_q_a[QUO_W-2:0]} + QUO_W'(r_rnd_a);
    assign w_lim = {1'b0, r_neg_a, {(ELEM_W-1){~r_neg_a}}};
    assign w_sat = r_q_a[QUO_W-1] | (w_qr > QUO_W'(w_lim));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_b <= w_sat ? w_lim[ELEM_W-1:0] : w_qr[ELEM_W-1:0];
            r_sat_b <= w_sat;
            r_neg_b <= r_neg_a;
        end
    end

    // Apply the sign of the quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.val <= r_neg_b ? (~r_mag_b + ELEM_W'(1)) : r_mag_b;
            r_res.sat <= r_sat_b;
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse by the adjugate.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------------
//  input    | in        | i_valid / o_stall      | i_e0 .. i_e8
//  result   | out       | o_valid / i_stall      | o_inv_e0 .. o_inv_e8, o_invertible,
//           |           |                        | o_saturated
//  config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_singular_tolerance
//
//  One matrix enters per clock unless a held result is stalled; o_valid follows the transfer
//  through nine cofactor and determinant stages, 38 divider stages and the output register.
//  Reset is synchronous and active low; it clears the valid bits, the skid entry and the
//  tolerance register.
//  A stall on the result side while a result is held freezes the whole pipeline; one input
//  item is then caught in a skid register, so o_stall is a register output.
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e0,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e1,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e2,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e3,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e4,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e5,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e6,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e7,
    input  logic signed [mi3_pkg::ELEM_W-1:0] i_e8,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e0,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e1,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e2,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e3,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e4,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e5,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e6,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e7,
    output logic signed [mi3_pkg::ELEM_W-1:0] o_inv_e8,
    output logic                         o_invertible,
    output logic                         o_saturated,
    // Configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mi3_pkg::TOL_W-1:0]    i_cfg_singular_tolerance
);
    import mi3_pkg::*;

    localparam int S_DIV = 8;                    // stage that feeds the dividers
    localparam int S_SG  = S_DIV + 1;            // stage of the singular decision
    localparam int S_OUT = S_DIV + DIV_LAT + 1;  // output register

    // Control
    logic [S_OUT:0]    r_v;
    logic              r_skid_v;
    logic [TOL_W-1:0]  r_tol;
    logic              w_en;
    logic              w_in_acc;
    logic              w_src_v;

    // Data path
    t_elem             w_in   [N_ELEM];
    t_elem             w_src  [N_ELEM];
    t_elem             r_skid [N_ELEM];
    t_elem             r_el   [S_OUT][N_ELEM];
    logic signed [PROD_W-1:0] r_pa [N_ELEM];
    logic signed [PROD_W-1:0] r_pb [N_ELEM];
    logic signed [ADJ_W-1:0]  r_adj [N_ELEM];
    logic [MAG_W-1:0]  r_cm [3:S_DIV][N_ELEM];
    logic              r_cs [3:S_DIV][N_ELEM];
    logic [ELEM_W-1:0] r_am [3];
    logic              r_ms [3];
    logic [PROD_W-1:0] r_lo [3];
    logic [PROD_W-1:0] r_hi [3];
    logic              r_ts4 [3];
    logic              r_ts5 [3];
    logic [TERM_W-1:0] r_tmag [3];
    logic signed [DET_W-1:0] r_term [3];
    logic signed [DET_W-1:0] r_det;
    logic              r_dneg;
    logic [DMAG_W-1:0] r_dmag;
    logic              r_sg [S_SG:S_OUT-1];
    t_div_res          w_res [N_ELEM];
    logic              w_any_sat;
    t_elem             r_o_inv [N_ELEM];
    logic              r_o_invertible;
    logic              r_o_saturated;

    assign w_in[0] = i_e0;
    assign w_in[1] = i_e1;
    assign w_in[2] = i_e2;
    assign w_in[3] = i_e3;
    assign w_in[4] = i_e4;
    assign w_in[5] = i_e5;
    assign w_in[6] = i_e6;
    assign w_in[7] = i_e7;
    assign w_in[8] = i_e8;

    // Handshake: the pipeline moves unless a finished result is held.
    assign w_en     = !(r_v[S_OUT] && i_stall);
    assign o_stall  = r_skid_v;
    assign w_in_acc = i_valid && !r_skid_v;
    assign w_src_v  = r_skid_v || w_in_acc;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            w_src[i] = r_skid_v ? r_skid[i] : w_in[i];
        end
    end

    // Valid bits, skid state and the tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_skid_v <= 1'b0;
            r_tol    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_singular_tolerance;
            end
            if (w_en) begin
                r_v      <= {r_v[S_OUT-1:0], w_src_v};
                r_skid_v <= 1'b0;
            end else if (w_in_acc) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // Skid register catches a transfer made while the pipeline is frozen.
    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid <= w_in;
        end
    end

    // Cofactor and determinant stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // Matrix elements travel alongside for the singular case.
            r_el[0] <= w_src;
            for (int s = 1; s < S_OUT; s++) begin
                r_el[s] <= r_el[s-1];
            end

            // Products of element pairs.
            for (int c = 0; c < N_ELEM; c++) begin
                r_pa[c] <= r_el[0][COF_IDX[c][0]] * r_el[0][COF_IDX[c][1]];
                r_pb[c] <= r_el[0][COF_IDX[c][2]] * r_el[0][COF_IDX[c][3]];
            end

            // Adjugate elements.
            for (int c = 0; c < N_ELEM; c++) begin
                r_adj[c] <= {r_pa[c][PROD_W-1], r_pa[c]} - {r_pb[c][PROD_W-1], r_pb[c]};
            end

            // Sign and magnitude of the adjugate and of the first row.
            for (int c = 0; c < N_ELEM; c++) begin
                r_cm[3][c] <= r_adj[c][ADJ_W-1] ? MAG_W'(-r_adj[c]) : MAG_W'(r_adj[c]);
                r_cs[3][c] <= r_adj[c][ADJ_W-1];
            end
            for (int t = 0; t < 3; t++) begin
                r_am[t] <= r_el[2][t][ELEM_W-1] ? ELEM_W'(-r_el[2][t]) : ELEM_W'(r_el[2][t]);
                r_ms[t] <= r_el[2][t][ELEM_W-1];
            end
            for (int s = 4; s <= S_DIV; s++) begin
                r_cm[s] <= r_cm[s-1];
                r_cs[s] <= r_cs[s-1];
            end

            // Expansion terms: element of the first row times its cofactor, in halves.
            for (int t = 0; t < 3; t++) begin
                r_lo[t]  <= r_am[t] * r_cm[3][3*t][ELEM_W-1:0];
                r_hi[t]  <= r_am[t] * r_cm[3][3*t][MAG_W-1:ELEM_W];
                r_ts4[t] <= r_ms[t] ^ r_cs[3][3*t];
            end

            // Join the halves.
            for (int t = 0; t < 3; t++) begin
                r_tmag[t] <= {r_hi[t], {ELEM_W{1'b0}}} + TERM_W'(r_lo[t]);
                r_ts5[t]  <= r_ts4[t];
            end

            // Signed terms.
            for (int t = 0; t < 3; t++) begin
                r_term[t] <= r_ts5[t] ? -DET_W'(r_tmag[t]) : DET_W'(r_tmag[t]);
            end

            // Determinant.
            r_det <= r_term[0] + r_term[1] + r_term[2];

            // Determinant sign and magnitude.
            r_dneg <= r_det[DET_W-1];
            r_dmag <= r_det[DET_W-1] ? DMAG_W'(-r_det) : DMAG_W'(r_det);

            // Singular when the magnitude is within the scaled tolerance.
            r_sg[S_SG] <= DMAG_W'({r_tol, {(2 * FRAC_BITS){1'b0}}}) >= r_dmag;
            for (int s = S_SG + 1; s < S_OUT; s++) begin
                r_sg[s] <= r_sg[s-1];
            end
        end
    end

    // Nine divider lanes, one per adjugate element.
    for (genvar i = 0; i < N_ELEM; i++) begin : g_div
        mi3_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_num_mag (r_cm[S_DIV][i]),
            .i_den     (r_dmag),
            .i_neg     (r_cs[S_DIV][i] ^ r_dneg),
            .o_res     (w_res[i])
        );
    end

    always_comb begin
        w_any_sat = 1'b0;
        for (int i = 0; i < N_ELEM; i++) begin
            w_any_sat = w_any_sat | w_res[i].sat;
        end
    end

    // Output register: echo the input for a singular matrix.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_o_inv[i] <= r_sg[S_OUT-1] ? r_el[S_OUT-1][i] : t_elem'(w_res[i].val);
            end
            r_o_invertible <= !r_sg[S_OUT-1];
            r_o_saturated  <= !r_sg[S_OUT-1] && w_any_sat;
        end
    end

    assign o_valid      = r_v[S_OUT];
    assign o_inv_e0     = r_o_inv[0];
    assign o_inv_e1     = r_o_inv[1];
    assign o_inv_e2     = r_o_inv[2];
    assign o_inv_e3     = r_o_inv[3];
    assign o_inv_e4     = r_o_inv[4];
    assign o_inv_e5     = r_o_inv[5];
    assign o_inv_e6     = r_o_inv[6];
    assign o_inv_e7     = r_o_inv[7];
    assign o_inv_e8     = r_o_inv[8];
    assign o_invertible = r_o_invertible;
    assign o_saturated  = r_o_saturated;

    // A singular result never reports saturation.
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invertible) |-> !o_saturated)
        else $error("singular result flagged as saturated");

    // A frozen pipeline keeps its valid bits.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v))
        else $error("valid bits moved while the pipeline was frozen");

    // The skid entry fills only from a transfer taken while frozen.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(w_in_acc && !w_en))
        else $error("skid entry filled without a frozen transfer");

endmodule
